// ----- src/bde_pkg.sv -----
// Shared types, codes and helpers for the bounded deque engine.
package bde_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int WORD_W       = 32;
    localparam int COUNT_W      = 7;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int TREE_FAN_LOG = 3;
    localparam int TREE_FAN     = 1 << TREE_FAN_LOG;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_OVERFLOW    = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_CLEAR_EMPTY = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic  push_front;
        logic  pop_front;
        logic  push_back;
        t_word value;
    } t_cell_ctl;

    // Register levels of the fan-in-8 OR tree over n leaves.
    function automatic int tree_levels(input int n);
        int lg;
        lg = $clog2(n);
        if (lg <= TREE_FAN_LOG) begin
            return 1;
        end
        return (lg + TREE_FAN_LOG - 1) / TREE_FAN_LOG;
    endfunction

endpackage

// ----- src/bde_req_if.sv -----
// Request channel: operation code and push value.
interface bde_req_if import bde_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [WORD_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- src/bde_rsp_if.sv -----
// Result channel: status, popped value and count after the operation.
interface bde_rsp_if import bde_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   popped_value;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output popped_value, output count,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input count,
                    output ready);
endinterface

// ----- src/bounded_deque_engine_core.sv -----
// Top level of the bounded deque engine: cell chain, back-value tree, control.
//
//  channel  | dir | transaction                     | handshake
//  ---------+-----+---------------------------------+-------------------
//  i_req    | in  | op, value                       | valid && ready
//  o_rsp    | out | status, popped_value, count     | valid && ready
//
// Push front, push back, pop front, clear and failed requests complete at the
// accepting edge: one request per cycle while o_rsp drains.
// A successful pop back reads the back cell through the registered OR tree and
// holds i_req off in S_SCAN until the value has climbed every tree level.
// i_rst_n (synchronous, active low) empties the queue; cell contents are not
// cleared and are never read before being written.
// A stalled o_rsp holds its transaction and blocks i_req until taken.
module bounded_deque_engine_core import bde_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bde_req_if.sink   i_req,
    bde_rsp_if.source o_rsp
);

    // count register must hold CAPACITY itself
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LVL = tree_levels(CAPACITY);
    localparam int SCW = $clog2(LVL + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [SCW-1:0]      r_scan, n_scan;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    t_word               r_out_popped, n_out_popped;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    t_cell_ctl           w_ctl;
    t_word               w_data [CAPACITY];
    t_word               w_tap  [CAPACITY];
    t_word               w_root;
    logic                w_accept;
    logic                w_commit;
    logic                w_full;
    logic                w_empty;
    t_op                 w_op;

    // ---------------------------------------------------------------
    // Cell chain: cell 0 is the front; values are left-aligned, so the
    // back lives in cell r_count-1. Front ops shift the whole row.
    // ---------------------------------------------------------------
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            t_word w_left;
            t_word w_right;
            if (i == 0) begin : g_head
                assign w_left = w_ctl.value;
            end else begin : g_mid_l
                assign w_left = w_data[i-1];
            end
            if (i == CAPACITY - 1) begin : g_tail
                assign w_right = w_data[i];
            end else begin : g_mid_r
                assign w_right = w_data[i+1];
            end
            bde_cell #(
                .IDX     (i),
                .COUNT_B (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_count (r_count),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[i]),
                .o_tap   (w_tap[i])
            );
        end
    endgenerate

    // Only the back cell drives a nonzero tap; the tree ORs them together.
    bde_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_tap),
        .o_root (w_root)
    );

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_op        = t_op'(i_req.op);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_commit    = (r_state == S_SCAN) && (r_scan == '0);

    always_comb begin
        n_state      = r_state;
        n_scan       = r_scan;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_count  = r_out_count;
        w_ctl        = '0;
        w_ctl.value  = i_req.value;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_popped = '0;
                    case (w_op)
                        OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                w_ctl.push_front = 1'b1;
                                n_count          = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                w_ctl.push_back = 1'b1;
                                n_count         = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                w_ctl.pop_front = 1'b1;
                                n_out_popped    = w_data[0];
                                n_count         = r_count - 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (w_empty) begin
                                n_out_status = ST_UNDERFLOW;
                            end else begin
                                // wait for the back value to climb the tree
                                n_out_valid = 1'b0;
                                n_state     = S_SCAN;
                                n_scan      = SCW'(LVL);
                            end
                        end
                        OP_CLEAR: begin
                            if (w_empty) begin
                                n_out_status = ST_CLEAR_EMPTY;
                            end else begin
                                n_count = '0;
                            end
                        end
                        default: ;  // unused codes: plain OK, nothing changes
                    endcase
                    n_out_count = COUNT_W'(n_count);
                end
            end
            S_SCAN: begin
                if (w_commit) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_popped = w_root;
                    n_count      = r_count - 1'b1;
                    n_out_count  = COUNT_W'(n_count);
                    n_state      = S_IDLE;
                end else begin
                    n_scan = r_scan - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.popped_value = r_out_popped;
    assign o_rsp.count        = r_out_count;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_back_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_count == $past(r_count) - 1'b1) && o_rsp.valid)
        else $error("pop back commit did not retire one entry");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(w_accept || w_commit))
        else $error("result appeared without a request");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_UNDERFLOW)) |-> (o_rsp.popped_value == '0))
        else $error("failed pop carries a value");

endmodule

// ----- src/bde_cell.sv -----
// One storage cell of the deque chain; slot IDX counted from the front.
module bde_cell import bde_pkg::*; #(
    parameter int IDX     = 0,
    parameter int COUNT_B = 7
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [COUNT_B-1:0] i_count,
    input  t_word              i_left,
    input  t_word              i_right,
    output t_word              o_data,
    output t_word              o_tap
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push_front) begin
            n_data = i_left;
        end else if (i_ctl.pop_front) begin
            n_data = i_right;
        end else if (i_ctl.push_back && (i_count == COUNT_B'(IDX))) begin
            n_data = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // this cell holds the back value
    assign o_tap  = (i_count == COUNT_B'(IDX + 1)) ? r_data : '0;

endmodule

// ----- src/bde_or_tree.sv -----
// Registered fan-in-8 OR tree collecting the single nonzero cell tap.
module bde_or_tree import bde_pkg::*; #(
    parameter int N = DEF_CAPACITY
) (
    input  logic  i_clk,
    input  t_word i_leaf [N],
    output t_word o_root
);

    localparam int LVL = tree_levels(N);
    localparam int PAD = 1 << (TREE_FAN_LOG * LVL);

    function automatic int level_off(input int k);
        int off;
        off = 0;
        for (int j = 1; j < k; j++) begin
            off += PAD >> (TREE_FAN_LOG * j);
        end
        return off;
    endfunction

    localparam int TOT = level_off(LVL + 1);

    t_word w_pad  [PAD];
    t_word r_node [TOT];

    genvar j, k, n;
    generate
        for (j = 0; j < PAD; j++) begin : g_pad
            if (j < N) begin : g_real
                assign w_pad[j] = i_leaf[j];
            end else begin : g_zero
                assign w_pad[j] = '0;
            end
        end

        for (k = 1; k <= LVL; k++) begin : g_lvl
            for (n = 0; n < (PAD >> (TREE_FAN_LOG * k)); n++) begin : g_node
                t_word w_sum;
                if (k == 1) begin : g_first
                    always_comb begin
                        w_sum = '0;
                        for (int c = 0; c < TREE_FAN; c++) begin
                            w_sum = w_sum | w_pad[TREE_FAN * n + c];
                        end
                    end
                end else begin : g_upper
                    always_comb begin
                        w_sum = '0;
                        for (int c = 0; c < TREE_FAN; c++) begin
                            w_sum = w_sum | r_node[level_off(k - 1) + TREE_FAN * n + c];
                        end
                    end
                end
                always_ff @(posedge i_clk) begin
                    r_node[level_off(k) + n] <= w_sum;
                end
            end
        end
    endgenerate

    assign o_root = r_node[TOT - 1];

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the bounded deque engine: directed table, then random bursts.
module tb;
    import bde_pkg::*;

    localparam int CAP           = DEF_CAPACITY;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 12;     // covers the multi-cycle pop back path
    localparam int MAX_REPORTS   = 10;

    // op codes outside the defined set; the block must ignore them
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    // random burst flavors
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_word               popped;
        logic [COUNT_W-1:0]  count;
    } t_deque_result;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        t_word               value;    // first value; repeated rows add the repetition index
        logic [7:0]          reps;
        logic                typed;    // expected result given in the row
        logic [STATUS_W-1:0] status;
        t_word               popped;
        logic [COUNT_W-1:0]  count;
    } t_stim_row;

    localparam t_stim_row DIRECTED [24] = '{
        // empty queue after reset
        '{OP_POP_FRONT,  32'h0000_0000, 8'd1,  1'b1, ST_UNDERFLOW,   32'h0000_0000, 7'd0},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 8'd1,  1'b1, ST_UNDERFLOW,   32'h0000_0000, 7'd0},
        '{OP_CLEAR,      32'hFFFF_FFFF, 8'd1,  1'b1, ST_CLEAR_EMPTY, 32'h0000_0000, 7'd0},
        // reserved codes are no-ops
        '{OP_RSVD_FIRST, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_RSVD_MID,   32'h0000_0000, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_RSVD_LAST,  32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd0},
        // single value round trips at the value extremes
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd1},
        '{OP_POP_BACK,   32'h0000_0000, 8'd1,  1'b1, ST_OK,          32'hFFFF_FFFF, 7'd0},
        '{OP_PUSH_BACK,  32'h0000_0000, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd1},
        '{OP_POP_FRONT,  32'hFFFF_FFFF, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_PUSH_BACK,  32'h5A5A_5A5A, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_POP_FRONT,  32'h0000_0000, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_POP_BACK,   32'h0000_0000, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        // fill to capacity, then push into the full queue from both ends
        '{OP_PUSH_BACK,  32'h1000_0000, 8'd64, 1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_PUSH_FRONT, 32'hDEAD_BEEF, 8'd1,  1'b1, ST_OVERFLOW,    32'h0000_0000, 7'd64},
        '{OP_PUSH_BACK,  32'hFFFF_FFFF, 8'd1,  1'b1, ST_OVERFLOW,    32'h0000_0000, 7'd64},
        '{OP_RSVD_LAST,  32'h0000_0000, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd64},
        '{OP_POP_FRONT,  32'h0000_0000, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_PUSH_FRONT, 32'h8000_0001, 8'd1,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_POP_BACK,   32'h0000_0000, 8'd3,  1'b0, ST_OK,          32'h0000_0000, 7'd0},
        // clear a populated queue, then an empty one
        '{OP_CLEAR,      32'h0000_0000, 8'd1,  1'b1, ST_OK,          32'h0000_0000, 7'd0},
        '{OP_CLEAR,      32'h0000_0000, 8'd1,  1'b1, ST_CLEAR_EMPTY, 32'h0000_0000, 7'd0},
        '{OP_POP_BACK,   32'h0000_0000, 8'd1,  1'b1, ST_UNDERFLOW,   32'h0000_0000, 7'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    bde_req_if req_if ();
    bde_rsp_if rsp_if ();

    bounded_deque_engine_core #(.CAPACITY(CAP)) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the deque
    t_word deque_slots [CAP];
    int    deque_front = 0;
    int    deque_count = 0;

    t_deque_result expected_results [$];
    int            mismatch_count = 0;
    bit            send_calm      = 1'b0;

    function automatic t_deque_result deque_step(input logic [OP_W-1:0] op,
                                                 input t_word value);
        t_deque_result res;
        res.status = ST_OK;
        res.popped = '0;
        case (op)
            OP_PUSH_FRONT: begin
                if (deque_count >= CAP) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    deque_front = (deque_front + CAP - 1) % CAP;
                    deque_slots[deque_front] = value;
                    deque_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (deque_count >= CAP) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    deque_slots[(deque_front + deque_count) % CAP] = value;
                    deque_count++;
                end
            end
            OP_POP_FRONT: begin
                if (deque_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.popped  = deque_slots[deque_front];
                    deque_front = (deque_front + 1) % CAP;
                    deque_count--;
                end
            end
            OP_POP_BACK: begin
                if (deque_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.popped = deque_slots[(deque_front + deque_count - 1) % CAP];
                    deque_count--;
                end
            end
            OP_CLEAR: begin
                if (deque_count == 0) begin
                    res.status = ST_CLEAR_EMPTY;
                end else begin
                    deque_count = 0;
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(deque_count);
        return res;
    endfunction

    // mostly short gaps, a few long ones; none in a calm stretch
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        int push_pct;
        int pop_pct;
        logic [OP_W-1:0] push_op;
        logic [OP_W-1:0] pop_op;
        r       = $urandom_range(0, 99);
        push_op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        pop_op  = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        case (mode)
            MODE_FILL: begin
                push_pct = 84;
                pop_pct  = 13;
            end
            MODE_DRAIN: begin
                push_pct = 13;
                pop_pct  = 84;
            end
            default: begin
                push_pct = 45;
                pop_pct  = 45;
            end
        endcase
        if (r < push_pct) return push_op;
        if (r < push_pct + pop_pct) return pop_op;
        if ($urandom_range(0, 1)) return OP_CLEAR;
        return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    endfunction

    // one request transaction; the expectation is taken at the accepting edge
    task automatic send_req(input logic [OP_W-1:0] op, input t_word value,
                            input bit typed, input t_deque_result typed_res);
        int gap;
        t_deque_result predicted;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.value <= value;
        do @(posedge clk); while (!req_if.ready);
        predicted = deque_step(op, value);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    initial begin : stimulus
        int mode;
        int burst_len;
        int sent;
        int r;
        logic [OP_W-1:0] op;
        t_word value;
        t_stim_row row;
        t_deque_result typed_res;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.op    <= OP_PUSH_FRONT;
        req_if.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) begin
            row              = DIRECTED[i];
            typed_res.status = row.status;
            typed_res.popped = row.popped;
            typed_res.count  = row.count;
            for (int k = 0; k < row.reps; k++) begin
                send_req(row.op, row.value + t_word'(k), row.typed, typed_res);
            end
        end

        // bursts that walk the queue between empty and full
        typed_res = '0;
        sent      = 0;
        while (sent < RANDOM_ITEMS) begin
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            burst_len = (mode == MODE_MIXED) ? $urandom_range(8, 40) : $urandom_range(20, 80);
            send_calm = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                op = pick_op(mode);
                r  = $urandom_range(0, 99);
                if (r < 8) begin
                    value = '0;
                end else if (r < 16) begin
                    value = '1;
                end else begin
                    value = $urandom;
                end
                send_req(op, value, 1'b0, typed_res);
                if (op < OP_RSVD_FIRST) sent++;
            end
        end
        req_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        int calm_left;
        bit calm;
        t_deque_result want;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: status %0d popped %h count %0d",
                                 rsp_if.status, rsp_if.popped_value, rsp_if.count);
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.popped_value !== want.popped ||
                        rsp_if.count !== want.count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: exp %0d %h %0d, got %0d %h %0d",
                                     want.status, want.popped, want.count,
                                     rsp_if.status, rsp_if.popped_value, rsp_if.count);
                    end
                end
            end
            // alternate calm stretches with stall-heavy ones
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = calm ? $urandom_range(30, 150) : $urandom_range(50, 300);
            end
            calm_left--;
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = pick_gap(calm);
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
